// File: rtl/core/rc4sc_pkg.sv
`default_nettype none

package rc4sc_pkg;

  // Permutation size.
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = 8;

  // Item kinds on the request channel.
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Request item: a key byte or a data byte.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       last;
  } req_item_t;

  // Result item: one enciphered or deciphered byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } rsp_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEN_RJ,
    ST_GEN_RT,
    ST_GEN_WB,
    ST_KS_INIT,
    ST_KS_RN,
    ST_KS_RJ,
    ST_KS_W1,
    ST_KS_W2
  } ctrl_state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT_KEY,
    OP_ACCEPT_DATA,
    OP_GEN_RJ,
    OP_GEN_RT,
    OP_GEN_WB,
    OP_KS_INIT,
    OP_KS_RN,
    OP_KS_RJ,
    OP_KS_W1,
    OP_KS_W2
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rc4sc_ctrl.sv
`default_nettype none

module rc4sc_ctrl import rc4sc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  input  dp_stat_t  stat,
  output dp_ctl_t   ctl
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register; reset starts the clearing pass over the permutation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.cmd == CMD_DATA) begin
            state_next = ST_GEN_RJ;
          end else if (req.last) begin
            state_next = ST_KS_INIT;
          end
        end
      end
      ST_GEN_RJ: state_next = ST_GEN_RT;
      ST_GEN_RT: state_next = ST_GEN_WB;
      ST_GEN_WB: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_KS_INIT: begin
        if (stat.cnt_last) state_next = ST_KS_RN;
      end
      ST_KS_RN: state_next = ST_KS_RJ;
      ST_KS_RJ: state_next = ST_KS_W1;
      ST_KS_W1: state_next = ST_KS_W2;
      ST_KS_W2: begin
        state_next = stat.cnt_last ? ST_IDLE : ST_KS_RN;
      end
    endcase
  end

  // Outputs: the ready flag and the datapath operation for this cycle.
  always_comb begin
    req_ready = 1'b0;
    ctl.op    = OP_NONE;
    unique case (state)
      ST_CLEAR: ctl.op = OP_CLEAR;
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.op = (req.cmd == CMD_DATA) ? OP_ACCEPT_DATA : OP_ACCEPT_KEY;
        end
      end
      ST_GEN_RJ:  ctl.op = OP_GEN_RJ;
      ST_GEN_RT:  ctl.op = OP_GEN_RT;
      ST_GEN_WB:  ctl.op = OP_GEN_WB;
      ST_KS_INIT: ctl.op = OP_KS_INIT;
      ST_KS_RN:   ctl.op = OP_KS_RN;
      ST_KS_RJ:   ctl.op = OP_KS_RJ;
      ST_KS_W1:   ctl.op = OP_KS_W1;
      ST_KS_W2:   ctl.op = OP_KS_W2;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rc4sc_datapath.sv
`default_nettype none

module rc4sc_datapath import rc4sc_pkg::*; #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req,
  input  dp_ctl_t   ctl,
  output dp_stat_t  stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int KW  = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int CW  = $clog2(KEY_MAX_BYTES + 1);
  localparam int KW1 = KW + 1;

  // Memories.
  logic [7:0] s_mem [SBOX_DEPTH];
  logic [7:0] s_rdata;
  logic [7:0] key_mem [KEY_MAX_BYTES];
  logic [7:0] key_rdata;

  // Control registers.
  logic [SBOX_AW-1:0] cnt;
  logic [SBOX_AW-1:0] idx_i;
  logic [SBOX_AW-1:0] idx_j;
  logic [CW-1:0]      key_count;
  logic [KW-1:0]      key_idx;
  logic               out_valid;

  // Payload registers.
  logic [7:0]         a_val;
  logic [7:0]         b_val;
  logic [SBOX_AW-1:0] t_idx;
  logic [7:0]         byte_hold;
  logic               last_hold;
  rsp_item_t          out_item;

  // Memory port controls.
  logic               s_we;
  logic               s_re;
  logic [SBOX_AW-1:0] s_waddr;
  logic [SBOX_AW-1:0] s_raddr;
  logic [7:0]         s_wdata;
  logic               key_we;
  logic               key_re;

  // Arithmetic.
  logic               key_room;
  logic [SBOX_AW-1:0] i_inc;
  logic [SBOX_AW-1:0] j_gen;
  logic [SBOX_AW-1:0] j_ks;
  logic [SBOX_AW-1:0] t_sum;
  logic [7:0]         ks_byte;
  logic [KW:0]        key_idx_inc;
  logic               key_wrap;

  assign key_room    = key_count < CW'(KEY_MAX_BYTES);
  assign i_inc       = idx_i + 8'd1;
  assign j_gen       = idx_j + s_rdata;
  assign j_ks        = idx_j + s_rdata + key_rdata;
  assign t_sum       = a_val + s_rdata;
  assign key_idx_inc = {1'b0, key_idx} + KW1'(1);
  assign key_wrap    = key_idx_inc >= KW1'(key_count);

  // The keystream entry was read before the swap reached memory, so the two
  // swapped places are taken from the held values instead.
  assign ks_byte = (t_idx == idx_j) ? a_val :
                   (t_idx == idx_i) ? b_val : s_rdata;

  assign stat.cnt_last = (cnt == 8'hFF);
  assign stat.out_free = !out_valid || rsp_ready;

  assign rsp_valid = out_valid;
  assign rsp       = out_item;

  // Permutation memory port selection.
  always_comb begin
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = cnt;
    s_raddr = cnt;
    s_wdata = 8'd0;
    key_re  = 1'b0;
    unique case (ctl.op)
      OP_NONE, OP_ACCEPT_KEY: begin
      end
      OP_CLEAR: begin
        s_we = 1'b1;
      end
      OP_ACCEPT_DATA: begin
        s_re    = 1'b1;
        s_raddr = i_inc;
      end
      OP_GEN_RJ: begin
        s_re    = 1'b1;
        s_raddr = j_gen;
      end
      OP_GEN_RT: begin
        s_we    = 1'b1;
        s_waddr = idx_i;
        s_wdata = s_rdata;
        s_re    = 1'b1;
        s_raddr = t_sum;
      end
      OP_GEN_WB: begin
        s_we    = 1'b1;
        s_waddr = idx_j;
        s_wdata = a_val;
      end
      OP_KS_INIT: begin
        s_we    = 1'b1;
        s_wdata = cnt;
      end
      OP_KS_RN: begin
        s_re   = 1'b1;
        key_re = 1'b1;
      end
      OP_KS_RJ: begin
        s_re    = 1'b1;
        s_raddr = j_ks;
      end
      OP_KS_W1: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
      end
      OP_KS_W2: begin
        s_we    = 1'b1;
        s_waddr = idx_j;
        s_wdata = a_val;
      end
    endcase
  end

  assign key_we = (ctl.op == OP_ACCEPT_KEY) && key_room;

  // Permutation memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_waddr] <= s_wdata;
    if (s_re) s_rdata <= s_mem[s_raddr];
  end

  // Key store memory.
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_count[KW-1:0]] <= req.data_byte;
    if (key_re) key_rdata <= key_mem[key_idx];
  end

  // Counters, indices and the result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      key_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      // A new result is loaded when the register is free; an old one stays until taken.
      out_valid <= (ctl.op == OP_GEN_WB && stat.out_free) || (out_valid && !rsp_ready);
      unique case (ctl.op)
        OP_NONE, OP_GEN_RT, OP_GEN_WB, OP_KS_RN, OP_KS_W1: begin
        end
        OP_CLEAR, OP_KS_INIT: begin
          cnt <= cnt + 8'd1;
        end
        OP_ACCEPT_KEY: begin
          if (key_room) key_count <= key_count + CW'(1);
          if (req.last) begin
            cnt     <= '0;
            idx_i   <= '0;
            idx_j   <= '0;
            key_idx <= '0;
          end
        end
        OP_ACCEPT_DATA: begin
          idx_i <= i_inc;
        end
        OP_GEN_RJ: begin
          idx_j <= j_gen;
        end
        OP_KS_RJ: begin
          idx_j <= j_ks;
        end
        OP_KS_W2: begin
          cnt     <= cnt + 8'd1;
          key_idx <= key_wrap ? '0 : key_idx_inc[KW-1:0];
          if (stat.cnt_last) begin
            idx_j     <= '0;
            key_count <= '0;
            key_idx   <= '0;
          end
        end
      endcase
    end
  end

  // Held operands and the result register.
  always_ff @(posedge clk) begin
    if (ctl.op == OP_ACCEPT_DATA) begin
      byte_hold <= req.data_byte;
      last_hold <= req.last;
    end
    if (ctl.op == OP_GEN_RJ || ctl.op == OP_KS_RJ) begin
      a_val <= s_rdata;
    end
    if (ctl.op == OP_GEN_RT) begin
      b_val <= s_rdata;
      t_idx <= t_sum;
    end
    if (ctl.op == OP_GEN_WB && stat.out_free) begin
      out_item.out_byte <= byte_hold ^ ks_byte;
      out_item.out_last <= last_hold;
    end
  end

  // A result appears only from the write-back step of a data item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctl.op == OP_GEN_WB))
    else $error("Result raised outside write-back.");

  // The end of the key schedule leaves the key count and the indices cleared.
  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_KS_W2 && stat.cnt_last) |=>
      (key_count == '0 && idx_j == '0 && idx_i == '0 && cnt == '0))
    else $error("Key schedule did not finish cleanly.");

  // The key count saturates at the store depth.
  a_key_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= CW'(KEY_MAX_BYTES))
    else $error("Key count beyond store depth.");

  // Each data item advances the first index by exactly one.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_ACCEPT_DATA) |=> (idx_i == $past(idx_i) + 8'd1))
    else $error("First index did not advance by one.");

endmodule

`default_nettype wire

// File: rtl/core/rc4_stream_cipher_top.sv
`default_nettype none

// RC4 stream cipher, one byte per item. A key item (cmd = 0) appends its byte
// to the key store; key bytes beyond KEY_MAX_BYTES are dropped. The key item
// with last set starts the key schedule, which keeps the block busy after that
// item: it loads the identity permutation, then makes the 256 swaps, all
// through the one write port of the permutation memory. A data item (cmd = 1)
// holds off the next item until it is done: it reads S[i], then S[j], then
// writes the swap while reading S[t], and writes back the second half of the
// swap while loading the result register. That sequence of dependent reads of
// one memory sets the rate. The result waits in its own register, so the next
// item can be taken while it is still unread; only a second result is held
// back until the first is taken. After reset the block zeroes the permutation
// before it accepts its first item. Data sent before any key comes back
// unchanged.

module rc4_stream_cipher_top import rc4sc_pkg::*; #(
  parameter int KEY_MAX_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // Sequencer.
  rc4sc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Memories, indices and the result register.
  rc4sc_datapath #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
